// File: rtl/hcbd_pkg.sv
package hcbd_pkg;

  localparam int unsigned SizeBitsDefault = 32;

  localparam logic [27:0] GrowCap = 28'hfff_ffff;

  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharSemi  = 8'h3b;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;

  localparam logic [1:0] StatusBusy       = 2'd0;
  localparam logic [1:0] StatusComplete   = 2'd1;
  localparam logic [1:0] StatusMalformed  = 2'd2;
  localparam logic [1:0] StatusIncomplete = 2'd3;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [1:0]  decode_status;
    logic [31:0] payload_total;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: rtl/hcbd_core.sv
module hcbd_core #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output hcbd_pkg::result_t result
);

  typedef enum logic [3:0] {
    PH_SIZE,
    PH_SIZE_CR,
    PH_EXT,
    PH_EXT_CR,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_TRAILER,
    PH_DONE,
    PH_BAD
  } phase_t;

  localparam logic [SIZE_BITS-1:0] GROW_LIMIT = (SIZE_BITS >= 32) ?
      SIZE_BITS'(hcbd_pkg::GrowCap) : {4'b0000, {(SIZE_BITS - 4){1'b1}}};

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] chunk_remaining, chunk_remaining_next;
  logic                 digit_seen, digit_seen_next;
  logic [1:0]           trailer_match, trailer_match_next;
  logic [31:0]          emitted_count, emitted_count_next;
  logic                 emit;
  hcbd_pkg::hex_t       hex;
  logic                 line_ok;
  logic [SIZE_BITS-1:0] remaining_dec;

  assign hex           = hcbd_pkg::hex_decode(data_byte);
  assign remaining_dec = chunk_remaining - SIZE_BITS'(1);

  always_comb begin
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    digit_seen_next      = digit_seen;
    trailer_match_next   = trailer_match;
    emitted_count_next   = emitted_count;
    emit                 = 1'b0;
    line_ok              = 1'b0;

    unique case (phase)
      PH_SIZE: begin
        if (data_byte == hcbd_pkg::CharSemi || data_byte == hcbd_pkg::CharSpace ||
            data_byte == hcbd_pkg::CharTab) begin
          phase_next = PH_EXT;
        end else if (data_byte == hcbd_pkg::CharCr) begin
          phase_next = PH_SIZE_CR;
        end else if (!hex.valid || chunk_remaining > GROW_LIMIT) begin
          phase_next = PH_BAD;
        end else begin
          chunk_remaining_next = {chunk_remaining[SIZE_BITS-5:0], hex.value};
          digit_seen_next      = 1'b1;
        end
      end
      PH_SIZE_CR: begin
        if (data_byte == hcbd_pkg::CharLf) begin
          line_ok = 1'b1;
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_EXT: begin
        if (data_byte == hcbd_pkg::CharCr) begin
          phase_next = PH_EXT_CR;
        end
      end
      PH_EXT_CR: begin
        if (data_byte == hcbd_pkg::CharLf) begin
          line_ok = 1'b1;
        end else if (data_byte != hcbd_pkg::CharCr) begin
          phase_next = PH_EXT;
        end
      end
      PH_DATA: begin
        emit                 = 1'b1;
        chunk_remaining_next = remaining_dec;
        if (emitted_count != '1) begin
          emitted_count_next = emitted_count + 32'd1;
        end
        if (remaining_dec == '0) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        phase_next = (data_byte == hcbd_pkg::CharCr) ? PH_DATA_LF : PH_BAD;
      end
      PH_DATA_LF: begin
        if (data_byte == hcbd_pkg::CharLf) begin
          phase_next           = PH_SIZE;
          chunk_remaining_next = '0;
          digit_seen_next      = 1'b0;
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_TRAILER: begin
        if (!trailer_match[0]) begin
          trailer_match_next = (data_byte == hcbd_pkg::CharCr) ?
                               trailer_match + 2'd1 : 2'd0;
        end else if (data_byte == hcbd_pkg::CharLf) begin
          if (trailer_match == 2'd3) begin
            phase_next = PH_DONE;
          end else begin
            trailer_match_next = 2'd2;
          end
        end else begin
          trailer_match_next = (data_byte == hcbd_pkg::CharCr) ? 2'd1 : 2'd0;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_next = PH_BAD;
      end
    endcase

    if (line_ok) begin
      if (!digit_seen) begin
        phase_next = PH_BAD;
      end else if (chunk_remaining == '0) begin
        phase_next         = PH_TRAILER;
        trailer_match_next = 2'd2;
      end else begin
        phase_next = PH_DATA;
      end
    end
  end

  always_comb begin
    result.payload_valid = emit;
    result.payload_byte  = emit ? data_byte : 8'd0;
    result.payload_total = emitted_count_next;
    if (phase_next == PH_DONE) begin
      result.decode_status = hcbd_pkg::StatusComplete;
    end else if (phase_next == PH_BAD) begin
      result.decode_status = hcbd_pkg::StatusMalformed;
    end else if (last_byte) begin
      result.decode_status = hcbd_pkg::StatusIncomplete;
    end else begin
      result.decode_status = hcbd_pkg::StatusBusy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      digit_seen      <= 1'b0;
      trailer_match   <= 2'd0;
      emitted_count   <= 32'd0;
    end else if (step) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      digit_seen      <= digit_seen_next;
      trailer_match   <= trailer_match_next;
      emitted_count   <= emitted_count_next;
    end
  end

endmodule

// File: rtl/http_chunked_body_decoder.sv
// Channel   Direction  tdata (low bit first)                      tuser          tlast
// s_axis    in         data_byte[7:0]                             -              last_byte
// m_axis    out        payload_byte, decode_status, payload_total payload_valid  -
//                      (zero padded to 48 bits)
//
// Every input beat yields exactly one output beat. Its result passes through the input register
// and then the output register before it is presented on m_axis.
// One beat per cycle is sustained while m_axis_tready stays high.
// The input register takes a new beat while a result waits in the output register.
// Reset returns the decoder to the start of a size line, as does any beat with tlast.
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // payload_byte, decode_status, payload_total, zeros
  output logic        m_axis_tuser    // payload_valid
);

  logic              in_valid;
  logic [7:0]        in_data;
  logic              in_last;
  logic              advance;
  hcbd_pkg::result_t result;
  hcbd_pkg::result_t out_result;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  hcbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_data),
    .last_byte (in_last),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_axis_tuser = out_result.payload_valid;
  assign m_axis_tdata = {6'b000000, out_result.payload_total, out_result.decode_status,
                         out_result.payload_byte};

endmodule
